// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ordered list insert engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OLIE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OLIE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/olie_pkg.sv =====
// Types, codes and constants shared by the ordered list insert engine.
package olie_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DEPTH_MAX = 64;
	localparam int IDX_W     = $clog2(DEPTH_MAX + 1);
	localparam int COUNT_W   = 5;

	localparam logic [2:0] KIND_APPEND  = 3'd0;
	localparam logic [2:0] KIND_PREPEND = 3'd1;
	localparam logic [2:0] KIND_INSERT  = 3'd2;
	localparam logic [2:0] KIND_READ    = 3'd3;
	localparam logic [2:0] KIND_COUNT   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         position;
		logic signed [31:0] value;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [COUNT_W-1:0] count;
		logic [1:0]         status;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_INSERT,
		OP_READ_STEP,
		OP_EMPTY,
		OP_REPORT
	} dp_op_t;

	typedef enum logic {
		S_IDLE,
		S_READOUT
	} state_t;

	typedef struct packed {
		dp_op_t             op;
		logic [IDX_W-1:0]   idx;
		logic signed [31:0] value;
		logic               last;
	} dp_cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0] occ;
		logic             empty;
	} dp_stat_t;

endpackage

// ===== sv/olie_datapath.sv =====
// Datapath: shifting cell chain, occupancy counter and result register.
module olie_datapath #(
	parameter int DEPTH = olie_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  olie_pkg::dp_cmd_t  cmd,
	output olie_pkg::dp_stat_t stat,
	output logic               valid,
	output olie_pkg::out_item_t result
);
	import olie_pkg::*;

	localparam int OCC_W = $clog2(DEPTH + 1);

	logic signed [31:0] cells_q [DEPTH];
	logic [OCC_W-1:0]   occ_q, occ_d, idx, last_idx;
	logic               full;
	logic               valid_q;
	out_item_t          res_q, res_d;

	assign idx      = cmd.idx[OCC_W-1:0];
	assign last_idx = occ_q - OCC_W'(1);
	assign full     = (occ_q == OCC_W'(DEPTH));

	// Insert shifts the tail up by one; a readout step rotates the occupied prefix.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		if (g == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (cmd.op == OP_INSERT && !full) begin
					if (idx == '0) begin
						cells_q[g] <= cmd.value;
					end
				end else if (cmd.op == OP_READ_STEP) begin
					if (last_idx != '0) begin
						cells_q[g] <= cells_q[g+1];
					end
				end
			end
		end else if (g == DEPTH - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (cmd.op == OP_INSERT && !full) begin
					if (OCC_W'(g) == idx) begin
						cells_q[g] <= cmd.value;
					end else if (OCC_W'(g) > idx && OCC_W'(g) <= occ_q) begin
						cells_q[g] <= cells_q[g-1];
					end
				end else if (cmd.op == OP_READ_STEP) begin
					if (OCC_W'(g) == last_idx) begin
						cells_q[g] <= cells_q[0];
					end
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.op == OP_INSERT && !full) begin
					if (OCC_W'(g) == idx) begin
						cells_q[g] <= cmd.value;
					end else if (OCC_W'(g) > idx && OCC_W'(g) <= occ_q) begin
						cells_q[g] <= cells_q[g-1];
					end
				end else if (cmd.op == OP_READ_STEP) begin
					if (OCC_W'(g) == last_idx) begin
						cells_q[g] <= cells_q[0];
					end else if (OCC_W'(g) < last_idx) begin
						cells_q[g] <= cells_q[g+1];
					end
				end
			end
		end
	end

	always_comb begin
		occ_d = occ_q;
		if (cmd.op == OP_INSERT && !full) begin
			occ_d = occ_q + OCC_W'(1);
		end
	end

	always_comb begin
		res_d.value_out = '0;
		res_d.count     = COUNT_W'(occ_d);
		res_d.status    = ST_OK;
		res_d.last      = 1'b1;
		unique case (cmd.op)
			OP_INSERT: begin
				if (full) begin
					res_d.status = ST_FULL;
				end
			end
			OP_READ_STEP: begin
				res_d.value_out = cells_q[0];
				res_d.last      = cmd.last;
			end
			OP_EMPTY: begin
				res_d.status = ST_EMPTY;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			occ_q   <= occ_d;
			valid_q <= (cmd.op != OP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != OP_NONE) begin
			res_q <= res_d;
		end
	end

	assign stat.occ   = IDX_W'(occ_q);
	assign stat.empty = (occ_q == '0);
	assign valid      = valid_q;
	assign result     = res_q;

endmodule

// ===== sv/olie_controller.sv =====
// Controller: decodes transactions and sequences readout steps.
module olie_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  olie_pkg::in_item_t item,
	input  olie_pkg::dp_stat_t stat,
	output logic               busy,
	output olie_pkg::dp_cmd_t  cmd
);
	import olie_pkg::*;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] rem_q, rem_d;
	logic [8:0]       pos9, occ9;

	assign pos9 = {1'b0, item.position};
	assign occ9 = 9'(stat.occ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		rem_d     = rem_q;
		busy      = (state_q == S_READOUT);
		cmd.op    = OP_NONE;
		cmd.idx   = '0;
		cmd.value = item.value;
		cmd.last  = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.kind)
						KIND_APPEND: begin
							cmd.op  = OP_INSERT;
							cmd.idx = stat.occ;
						end
						KIND_PREPEND: begin
							cmd.op = OP_INSERT;
						end
						KIND_INSERT: begin
							cmd.op = OP_INSERT;
							if (item.position == '0) begin
								cmd.idx = '0;
							end else if (pos9 >= occ9 + 9'd1) begin
								cmd.idx = stat.occ;
							end else begin
								cmd.idx = IDX_W'(item.position - 8'd1);
							end
						end
						KIND_READ: begin
							if (stat.empty) begin
								cmd.op = OP_EMPTY;
							end else begin
								cmd.op   = OP_READ_STEP;
								cmd.last = (stat.occ == IDX_W'(1));
								if (stat.occ != IDX_W'(1)) begin
									state_d = S_READOUT;
									rem_d   = stat.occ - IDX_W'(1);
								end
							end
						end
						default: begin
							cmd.op = OP_REPORT;
						end
					endcase
				end
			end
			S_READOUT: begin
				cmd.op   = OP_READ_STEP;
				cmd.last = (rem_q == IDX_W'(1));
				rem_d    = rem_q - IDX_W'(1);
				if (rem_q == IDX_W'(1)) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/ordered_list_insert_engine.sv =====
// Top level: ordered list insert engine, controller plus cell-chain datapath.
//
// A transaction is taken when start is high and busy is low. Append, prepend,
// insert and count report each give one result, with valid in the next cycle;
// a new transaction can be started every cycle while busy is low. A readout
// of N stored entries gives N results, one entry per cycle from the head cell
// of the chain while the occupied cells rotate back into place; busy stays
// high after the accepting cycle while the remaining steps are issued. Results
// appear on result for exactly one cycle with valid high and cannot be held
// off, so the receiver must take every valid cycle. A readout of an empty
// store, and an insert into a full store, each return one flagged result.
`include "assert_macros.svh"

module ordered_list_insert_engine #(
	parameter int DEPTH = olie_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  olie_pkg::in_item_t  item,
	output logic                busy,
	output logic                valid,
	output olie_pkg::out_item_t result
);
	import olie_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	olie_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	olie_datapath #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat),
		.valid  (valid),
		.result (result)
	);

	`OLIE_ASSERT_NXT(a_busy_gives_result, clk, arst_n, busy, valid, "readout step lost")
	`OLIE_ASSERT_NXT(a_readout_no_gap, clk, arst_n, valid && !result.last, valid, "readout gap")
	`OLIE_ASSERT_IMP(a_empty_shape, clk, arst_n, valid && result.status == ST_EMPTY,
		result.last && result.count == '0 && result.value_out == '0, "bad empty result")
	`OLIE_ASSERT_NXT(a_start_idle_result, clk, arst_n, start && !busy, valid, "no result")

endmodule

// ===== test/tb_ordered_list_insert_engine.sv =====
// Testbench for the ordered list insert engine: directed and random command traffic.
module tb_ordered_list_insert_engine;
	import olie_pkg::*;

	localparam int CELLS = DEPTH_DEF;
	localparam int DRAIN_CYCLES = CELLS + 4;
	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	in_item_t item;
	logic busy;
	logic valid;
	out_item_t result;

	ordered_list_insert_engine #(.DEPTH(CELLS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.valid(valid),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the cell chain
	logic signed [31:0] shadow_cells [0:CELLS-1];
	int shadow_fill = 0;

	out_item_t pending_results[$];
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int readouts = 0;
	int dropped_inserts = 0;
	bit idling_on = 1'b1;

	function automatic out_item_t make_result(logic signed [31:0] v, logic [1:0] st, logic lst);
		out_item_t r;
		r.value_out = v;
		r.count = shadow_fill[COUNT_W-1:0];
		r.status = st;
		r.last = lst;
		return r;
	endfunction

	function void predict_list_op(in_item_t it);
		int slot;
		int pos;
		logic [1:0] st;
		slot = 0;
		pos = it.position;
		st = ST_OK;
		case (it.kind)
			KIND_APPEND, KIND_PREPEND, KIND_INSERT: begin
				if (it.kind == KIND_APPEND)
					slot = shadow_fill;
				else if (it.kind == KIND_PREPEND)
					slot = 0;
				else begin
					if (pos == 0)
						pos = 1;
					slot = (pos >= shadow_fill + 1) ? shadow_fill : pos - 1;
				end
				if (shadow_fill >= CELLS) begin
					st = ST_FULL;
					dropped_inserts++;
				end else begin
					for (int i = shadow_fill; i > slot; i--)
						shadow_cells[i] = shadow_cells[i-1];
					shadow_cells[slot] = it.value;
					shadow_fill++;
				end
				pending_results.push_back(make_result('0, st, 1'b1));
			end
			KIND_READ: begin
				readouts++;
				if (shadow_fill == 0)
					pending_results.push_back(make_result('0, ST_EMPTY, 1'b1));
				else
					for (int i = 0; i < shadow_fill; i++)
						pending_results.push_back(make_result(shadow_cells[i], ST_OK,
							i == shadow_fill - 1));
			end
			default: pending_results.push_back(make_result('0, ST_OK, 1'b1));
		endcase
	endfunction

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result %p", $time, got);
			mismatches++;
		end else begin
			want = pending_results.pop_front();
			results_checked++;
			if (got.value_out !== want.value_out) begin
				$display("%0t: value_out expected %0d actual %0d", $time,
					want.value_out, got.value_out);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d", $time,
					want.status, got.status);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && valid)
			check_result(result);
	end

	// called at a falling edge, returns at a falling edge with start low
	task automatic send_item(in_item_t it);
		start = 1'b1;
		item = it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_list_op(it);
		items_sent++;
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic send_op(logic [2:0] k, logic [7:0] p, logic signed [31:0] v);
		in_item_t it;
		it.kind = k;
		it.position = p;
		it.value = v;
		send_item(it);
	endtask

	task automatic maybe_idle();
		if (idling_on && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 16))
				@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	function automatic in_item_t random_op(bit insert_heavy);
		in_item_t it;
		int pick;
		pick = insert_heavy ? $urandom_range(0, 15) : $urandom_range(0, 19);
		if (pick < 4)
			it.kind = KIND_APPEND;
		else if (pick < 7)
			it.kind = KIND_PREPEND;
		else if (pick < 12)
			it.kind = KIND_INSERT;
		else if (pick < 15)
			it.kind = KIND_READ;
		else if (pick < 17)
			it.kind = KIND_COUNT;
		else
			it.kind = 3'($urandom_range(5, 7));
		if ($urandom_range(0, 1))
			it.position = 8'($urandom_range(0, shadow_fill + 2));
		else
			it.position = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 7))
			0: it.value = 32'sh7fffffff;
			1: it.value = 32'sh80000000;
			2: it.value = '0;
			3: it.value = '1;
			default: it.value = $urandom();
		endcase
		return it;
	endfunction

	task automatic test_empty_store();
		send_op(KIND_READ, 8'd0, '0);
		send_op(KIND_COUNT, 8'd0, '0);
		send_op(3'd5, 8'hff, '1);
	endtask

	task automatic test_insert_kinds();
		send_op(KIND_APPEND, 8'd0, 32'sh7fffffff);
		send_op(KIND_PREPEND, 8'hff, 32'sh80000000);
		send_op(KIND_INSERT, 8'd0, -32'sd1);
		send_op(KIND_INSERT, 8'hff, '0);
		send_op(KIND_INSERT, 8'd2, 32'sh55555555);
		send_op(KIND_INSERT, 8'd6, 32'shaaaaaaaa);
		send_op(KIND_INSERT, 8'd6, 32'sh0000ffff);
		send_op(3'd6, 8'h55, 32'sh12345678);
		send_op(3'd7, 8'haa, 32'sh87654321);
		send_op(KIND_COUNT, 8'd0, '0);
		send_op(KIND_READ, 8'd0, '0);
	endtask

	task automatic test_random_fill();
		repeat (40) begin
			send_item(random_op(1'b1));
			maybe_idle();
		end
	endtask

	task automatic test_full_store();
		while (shadow_fill < CELLS)
			send_op(KIND_INSERT, 8'($urandom_range(0, shadow_fill + 1)), $urandom());
		send_op(KIND_APPEND, 8'd0, 32'sh7fffffff);
		send_op(KIND_PREPEND, 8'd0, 32'sh80000000);
		send_op(KIND_INSERT, 8'd0, '1);
		send_op(KIND_INSERT, 8'hff, '0);
		send_op(KIND_READ, 8'd0, '0);
		send_op(KIND_COUNT, 8'd0, '0);
	endtask

	task automatic test_pause_until_drained();
		send_op(KIND_READ, 8'd0, '0);
		wait_drained();
		send_op(KIND_COUNT, 8'd0, '0);
	endtask

	task automatic test_random_traffic();
		repeat (280) begin
			send_item(random_op(1'b0));
			maybe_idle();
		end
	endtask

	task automatic test_back_to_back_tail();
		idling_on = 1'b0;
		repeat (30)
			send_item(random_op(1'b0));
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		repeat (5)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_empty_store();
		test_insert_kinds();
		test_random_fill();
		test_full_store();
		test_pause_until_drained();
		test_random_traffic();
		test_back_to_back_tail();
		wait_drained();
		$display("Sent %0d commands (%0d readouts, %0d dropped inserts) with random gaps,",
			items_sent, readouts, dropped_inserts);
		$display("checked %0d results against the shadow list.", results_checked);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ordered_list_insert_engine: match");
		else
			$display("ordered_list_insert_engine: mismatch");
		$finish;
	end

	initial begin
		#(12 * LIMIT_CYCLES);
		$display("Timed out with %0d results outstanding", pending_results.size());
		$display("ordered_list_insert_engine: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/olie_pkg.sv
sv/olie_datapath.sv
sv/olie_controller.sv
sv/ordered_list_insert_engine.sv
test/tb_ordered_list_insert_engine.sv
